@@ hw/rtl/rc4_pkg.sv @@
package rc4_pkg;

  localparam int SBOX_SIZE   = 256;
  localparam int MAX_KEY_LEN = 256;

  localparam int IDX_W      = $clog2(SBOX_SIZE);
  localparam int KEY_CNT_W  = $clog2(MAX_KEY_LEN + 1);
  localparam int KEY_ADDR_W = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

  localparam logic FUNC_LOAD_KEY = 1'b0;
  localparam logic FUNC_GENERATE = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_GJ   = 8'b0000_0010,
    ST_GSW  = 8'b0000_0100,
    ST_GOUT = 8'b0000_1000,
    ST_KRD  = 8'b0001_0000,
    ST_KJ   = 8'b0010_0000,
    ST_KW1  = 8'b0100_0000,
    ST_KW2  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } sbox_req_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_byte;
    logic       wr_last;
    logic       rd_en;
  } key_req_t;

endpackage

@@ hw/rtl/rc4_sbox.sv @@
module rc4_sbox (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rc4_pkg::sbox_req_t             req,
  output logic [rc4_pkg::IDX_W-1:0]      rdata
);

  logic [rc4_pkg::IDX_W-1:0]   mem_r [rc4_pkg::SBOX_SIZE];
  logic [rc4_pkg::SBOX_SIZE-1:0] valid_r;
  logic [rc4_pkg::IDX_W-1:0]   rd_mem_r;
  logic [rc4_pkg::IDX_W-1:0]   rd_addr_r;
  logic                        rd_valid_r;

  // entries not written since the last clear read as the identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else if (req.re) begin
      rd_valid_r <= valid_r[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_mem_r  <= mem_r[req.raddr];
      rd_addr_r <= req.raddr;
    end
  end

  assign rdata = rd_valid_r ? rd_mem_r : rd_addr_r;

endmodule

@@ hw/rtl/rc4_keystore.sv @@
module rc4_keystore (
  input  logic              clk,
  input  logic              rst_n,
  input  rc4_pkg::key_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0]                       key_mem_r [rc4_pkg::MAX_KEY_LEN];
  logic [rc4_pkg::KEY_CNT_W-1:0]    key_count_r;
  logic [rc4_pkg::KEY_CNT_W-1:0]    key_count_nxt;
  logic [rc4_pkg::KEY_CNT_W-1:0]    len_r;
  logic [rc4_pkg::KEY_CNT_W-1:0]    len_nxt;
  logic [rc4_pkg::KEY_ADDR_W-1:0]   kidx_r;
  logic [rc4_pkg::KEY_ADDR_W-1:0]   kidx_nxt;
  logic [7:0]                       rd_data_r;
  logic                             not_full;
  logic                             kidx_wrap;

  assign not_full  = key_count_r < rc4_pkg::KEY_CNT_W'(rc4_pkg::MAX_KEY_LEN);
  assign kidx_wrap = (rc4_pkg::KEY_CNT_W'(kidx_r) + rc4_pkg::KEY_CNT_W'(1)) == len_r;

  always_comb begin
    key_count_nxt = key_count_r;
    len_nxt       = len_r;
    kidx_nxt      = kidx_r;
    if (req.wr_en) begin
      if (not_full) begin
        key_count_nxt = key_count_r + rc4_pkg::KEY_CNT_W'(1);
      end
      if (req.wr_last) begin
        len_nxt       = key_count_nxt;
        key_count_nxt = '0;
        kidx_nxt      = '0;
      end
    end else if (req.rd_en) begin
      kidx_nxt = kidx_wrap ? '0 : kidx_r + rc4_pkg::KEY_ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      len_r       <= rc4_pkg::KEY_CNT_W'(1);
      kidx_r      <= '0;
    end else begin
      key_count_r <= key_count_nxt;
      len_r       <= len_nxt;
      kidx_r      <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en && not_full) begin
      key_mem_r[key_count_r[rc4_pkg::KEY_ADDR_W-1:0]] <= req.wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= key_mem_r[kidx_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rc4_keystream_generator.sv @@
// Generate beat: taken only in ST_IDLE, then ST_GJ, ST_GSW, ST_GOUT, set by the dependent
//   S-box reads; ST_GOUT registers the result, waiting while a held result blocks output.
// Key-load beat: taken in ST_IDLE; key_last starts the key schedule, ST_KRD, ST_KJ, ST_KW1
//   and ST_KW2 per S-box entry with in_tready low, then the block is ready again.
// Reset: indices and key count cleared, S-box valid bits cleared so it reads as the
//   identity; no clearing pass.
module rc4_keystream_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] key_byte
  input  logic       in_tuser,   // [0] func
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] keystream_byte
);

  rc4_pkg::state_t             state_r, state_nxt;
  logic [rc4_pkg::IDX_W-1:0]   i_r, i_nxt;
  logic [rc4_pkg::IDX_W-1:0]   j_r, j_nxt;
  logic [rc4_pkg::IDX_W-1:0]   k_r, k_nxt;
  logic [rc4_pkg::IDX_W-1:0]   si_r, si_nxt;
  logic [rc4_pkg::IDX_W-1:0]   sj_r, sj_nxt;
  logic [rc4_pkg::IDX_W-1:0]   t_r, t_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_data_r, out_data_nxt;
  logic [rc4_pkg::IDX_W-1:0]   sbox_rdata;
  logic [7:0]                  key_rdata;
  logic [rc4_pkg::IDX_W-1:0]   jj_sum;
  logic                        in_fire;
  logic                        out_free;
  rc4_pkg::sbox_req_t          sbox_req;
  rc4_pkg::key_req_t           key_req;

  rc4_sbox u_sbox (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sbox_req),
    .rdata (sbox_rdata)
  );

  rc4_keystore u_keystore (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (key_req),
    .rd_data (key_rdata)
  );

  assign in_tready = (state_r == rc4_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign jj_sum    = j_r + sbox_rdata + key_rdata;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    sbox_req      = '0;
    key_req       = '0;
    key_req.wr_byte = in_tdata;
    key_req.wr_last = in_tlast;

    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == rc4_pkg::FUNC_GENERATE) begin
            i_nxt          = i_r + rc4_pkg::IDX_W'(1);
            sbox_req.re    = 1'b1;
            sbox_req.raddr = i_r + rc4_pkg::IDX_W'(1);
            state_nxt      = rc4_pkg::ST_GJ;
          end else begin
            key_req.wr_en = 1'b1;
            if (in_tlast) begin
              sbox_req.clr = 1'b1;
              j_nxt        = '0;
              k_nxt        = '0;
              state_nxt    = rc4_pkg::ST_KRD;
            end
          end
        end
      end
      rc4_pkg::ST_GJ: begin
        si_nxt         = sbox_rdata;
        j_nxt          = j_r + sbox_rdata;
        sbox_req.re    = 1'b1;
        sbox_req.raddr = j_r + sbox_rdata;
        state_nxt      = rc4_pkg::ST_GSW;
      end
      rc4_pkg::ST_GSW: begin
        sj_nxt         = sbox_rdata;
        sbox_req.we    = 1'b1;
        sbox_req.waddr = i_r;
        sbox_req.wdata = sbox_rdata;
        t_nxt          = si_r + sbox_rdata;
        sbox_req.re    = 1'b1;
        sbox_req.raddr = si_r + sbox_rdata;
        state_nxt      = rc4_pkg::ST_GOUT;
      end
      rc4_pkg::ST_GOUT: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_r;
        sbox_req.wdata = si_r;
        if (out_free) begin
          // forward the swapped entries; the RAM read saw the old values
          priority if (t_r == i_r) begin
            out_data_nxt = sj_r;
          end else if (t_r == j_r) begin
            out_data_nxt = si_r;
          end else begin
            out_data_nxt = sbox_rdata;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = rc4_pkg::ST_IDLE;
        end
      end
      rc4_pkg::ST_KRD: begin
        sbox_req.re    = 1'b1;
        sbox_req.raddr = k_r;
        key_req.rd_en  = 1'b1;
        state_nxt      = rc4_pkg::ST_KJ;
      end
      rc4_pkg::ST_KJ: begin
        si_nxt         = sbox_rdata;
        j_nxt          = jj_sum;
        sbox_req.re    = 1'b1;
        sbox_req.raddr = jj_sum;
        state_nxt      = rc4_pkg::ST_KW1;
      end
      rc4_pkg::ST_KW1: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = k_r;
        sbox_req.wdata = sbox_rdata;
        state_nxt      = rc4_pkg::ST_KW2;
      end
      rc4_pkg::ST_KW2: begin
        sbox_req.we    = 1'b1;
        sbox_req.waddr = j_r;
        sbox_req.wdata = si_r;
        k_nxt          = k_r + rc4_pkg::IDX_W'(1);
        if (k_r == rc4_pkg::IDX_W'(rc4_pkg::SBOX_SIZE - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = rc4_pkg::ST_IDLE;
        end else begin
          state_nxt = rc4_pkg::ST_KRD;
        end
      end
      default: begin
        state_nxt = rc4_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_out_from_gen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == rc4_pkg::ST_GOUT))
    else $error("result appeared outside the output step");

  a_gout_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_GOUT && out_tvalid && !out_tready) |=>
      (state_r == rc4_pkg::ST_GOUT))
    else $error("output step left while result register busy");

  a_ks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rc4_pkg::ST_KW2 && k_r == rc4_pkg::IDX_W'(rc4_pkg::SBOX_SIZE - 1)) |=>
      (state_r == rc4_pkg::ST_IDLE && i_r == '0 && j_r == '0))
    else $error("key schedule did not end with cleared indices");

endmodule
